[src/pit_pkg.sv]
// Shared widths, state encoding and permutation tables for the PIT loss block.
package pit_pkg;

  // Sample and accumulator widths
  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int MAX_LEN   = 65536;
  localparam int LEN_W     = 17;
  localparam int ACC_W     = SQ_W + LEN_W - 1;
  localparam int SCORE_W   = ACC_W + 2;
  localparam int NUM_LANES = 9;
  localparam int LANE_IW   = 4;

  // Batch and result widths
  localparam int MAX_BATCH = 256;
  localparam int UCNT_W    = 9;
  localparam int LOSS_W    = 33;
  localparam int BSUM_W    = LOSS_W + UCNT_W - 1;
  localparam int PERM_W    = 3;

  // Shared divider sizes
  localparam int DVD_W     = SCORE_W;
  localparam int DVS_W     = LEN_W + 1;
  localparam int DCNT_W    = $clog2(DVD_W);

  localparam logic [1:0] SPK_THREE = 2'd3;
  localparam logic [1:0] SPK_RESET = 2'd2;

  typedef logic [NUM_LANES-1:0][ACC_W-1:0] lane_arr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_SCORE,
    S_DIV_UTT,
    S_BATCH,
    S_DIV_BATCH,
    S_OUT
  } state_t;

  // Source predicted speaker for reference speaker i, lexicographic order
  localparam logic [1:0] PERM3 [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
  };
  localparam logic [1:0] PERM2 [2][2] = '{'{2'd0, 2'd1}, '{2'd1, 2'd0}};

  function automatic logic [1:0] perm_src(input logic three, input logic [2:0] k,
                                          input logic [1:0] i);
    logic [1:0] src;
    src = 2'd0;
    if (three) begin
      if (k < 3'd6 && i < 2'd3) src = PERM3[k][i];
    end else begin
      if (i < 2'd2) src = PERM2[k[0]][i[0]];
    end
    return src;
  endfunction

endpackage

[src/pit_lane.sv]
// One pairing lane: squared difference of two samples, accumulated per utterance.
module pit_lane
  import pit_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       clr,
  input  logic signed [SAMPLE_W-1:0] pred,
  input  logic signed [SAMPLE_W-1:0] targ,
  output logic        [ACC_W-1:0]    acc
);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic        [SQ_W-1:0]     sq;
  logic                       sq_valid;

  // difference and square, registered before the add
  assign diff = DIFF_W'(pred) - DIFF_W'(targ);
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq <= prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= en;
    end
  end

  // running sum for this pairing
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      acc <= '0;
    end else if (sq_valid) begin
      acc <= acc + ACC_W'(sq);
    end
  end

endmodule

[src/pit_perm.sv]
// Merging stage: scores each permutation from the lane sums, keeps the minimum.
module pit_perm
  import pit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               three,
  input  lane_arr_t          lanes,
  output logic [SCORE_W-1:0] best,
  output logic [PERM_W-1:0]  best_idx,
  output logic               fin
);

  logic [2:0]         k;
  logic               run;
  logic [SCORE_W-1:0] sc;
  logic [PERM_W-1:0]  sc_idx;
  logic               sc_valid;
  logic               sc_last;
  logic [SCORE_W-1:0] score;
  logic [LANE_IW-1:0] idx0, idx1, idx2;
  logic               k_last;

  // lane (src, i) sits at 3*src + i
  assign idx0 = LANE_IW'({2'b00, perm_src(three, k, 2'd0)} * 4'd3);
  assign idx1 = LANE_IW'({2'b00, perm_src(three, k, 2'd1)} * 4'd3 + 4'd1);
  assign idx2 = LANE_IW'({2'b00, perm_src(three, k, 2'd2)} * 4'd3 + 4'd2);

  assign score = SCORE_W'(lanes[idx0]) + SCORE_W'(lanes[idx1])
               + (three ? SCORE_W'(lanes[idx2]) : '0);
  assign k_last = three ? (k == 3'd5) : (k == 3'd1);

  // issue one permutation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      sc_valid <= 1'b0;
      fin      <= 1'b0;
    end else begin
      fin <= sc_valid && sc_last;
      if (start) begin
        run      <= 1'b1;
        sc_valid <= 1'b0;
      end else begin
        sc_valid <= run;
        if (run && k_last) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k <= '0;
    end else if (run) begin
      k <= k + 3'd1;
    end
    sc      <= score;
    sc_idx  <= PERM_W'(k);
    sc_last <= k_last;
  end

  // strict less-than keeps the first minimum on ties
  always_ff @(posedge clk) begin
    if (start) begin
      best     <= '1;
      best_idx <= '0;
    end else if (sc_valid && sc < best) begin
      best     <= sc;
      best_idx <= sc_idx;
    end
  end

endmodule

[src/pit_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both mean computations.
module pit_div
  import pit_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             fin
);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic              run;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == DCNT_W'(DVD_W - 1)) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  // datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (run) begin
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
      cnt <= cnt + DCNT_W'(1);
    end
  end

  assign quotient = dvd;

endmodule

[src/permutation_invariant_mse_loss.sv]
// Top level: utterance-level permutation invariant MSE loss over a streamed batch.
// Sample words are taken one per cycle while busy is low; nine lanes accumulate them.
// A word with last_sample raises busy while the 2 or 6 permutations are scored and the
// bit-serial divider forms the mean, and again for the batch mean when it closes the batch.
// The result is shown for one cycle on result_valid; the receiver cannot stall it.
// Synchronous reset clears lanes, counts, batch sums; speaker_count returns to 2.
module permutation_invariant_mse_loss
  import pit_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] pred_first,
  input  logic signed [SAMPLE_W-1:0] pred_second,
  input  logic signed [SAMPLE_W-1:0] pred_third,
  input  logic signed [SAMPLE_W-1:0] ref_first,
  input  logic signed [SAMPLE_W-1:0] ref_second,
  input  logic signed [SAMPLE_W-1:0] ref_third,
  input  logic                       last_sample,
  input  logic                       last_utterance,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_data,
  output logic                       result_valid,
  output logic [LOSS_W-1:0]          utterance_loss,
  output logic [PERM_W-1:0]          best_permutation,
  output logic [LOSS_W-1:0]          batch_loss,
  output logic                       batch_done
);

  state_t state, state_next;

  logic [1:0]            speaker_count;
  logic                  three;
  logic                  accept;
  logic                  lane_en;
  logic                  lane_clr;
  logic [LEN_W-1:0]      sample_count;
  logic                  batch_flag;
  lane_arr_t             lane_sums;
  logic signed [SAMPLE_W-1:0] pred_arr [3];
  logic signed [SAMPLE_W-1:0] targ_arr [3];

  logic                  perm_start;
  logic                  perm_fin;
  logic [SCORE_W-1:0]    best_score;

  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [DVS_W-1:0]      div_dvs;
  logic [DVD_W-1:0]      div_q;
  logic                  div_fin;

  logic [LOSS_W-1:0]     loss;
  logic [LOSS_W-1:0]     batch_mean;
  logic [BSUM_W-1:0]     batch_sum;
  logic [UCNT_W-1:0]     utt_count;
  logic                  batch_room;
  logic [BSUM_W-1:0]     batch_sum_add;
  logic [UCNT_W-1:0]     utt_count_add;
  logic [DVS_W-1:0]      len_div;

  assign three   = (speaker_count == SPK_THREE);
  assign accept  = start && !busy;
  assign lane_en = accept && (sample_count < LEN_W'(MAX_LEN));

  // configuration register
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      speaker_count <= SPK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speaker_count <= cfg_data;
    end
  end

  // nine pairing lanes, lane 3*p + r
  assign pred_arr[0] = pred_first;
  assign pred_arr[1] = pred_second;
  assign pred_arr[2] = pred_third;
  assign targ_arr[0] = ref_first;
  assign targ_arr[1] = ref_second;
  assign targ_arr[2] = ref_third;

  for (genvar p = 0; p < 3; p++) begin : g_pred
    for (genvar r = 0; r < 3; r++) begin : g_targ
      pit_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .en   (lane_en),
        .clr  (lane_clr),
        .pred (pred_arr[p]),
        .targ (targ_arr[r]),
        .acc  (lane_sums[3*p + r])
      );
    end
  end

  pit_perm u_perm (
    .clk      (clk),
    .rst      (rst),
    .start    (perm_start),
    .three    (three),
    .lanes    (lane_sums),
    .best     (best_score),
    .best_idx (best_permutation),
    .fin      (perm_fin)
  );

  pit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .fin      (div_fin)
  );

  // sample count and batch flag
  always_ff @(posedge clk) begin
    if (rst || lane_clr) begin
      sample_count <= '0;
    end else if (lane_en) begin
      sample_count <= sample_count + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) batch_flag <= last_utterance;
  end

  // batch accumulation
  assign batch_room    = utt_count < UCNT_W'(MAX_BATCH);
  assign batch_sum_add = batch_room ? batch_sum + BSUM_W'(loss) : batch_sum;
  assign utt_count_add = batch_room ? utt_count + UCNT_W'(1) : utt_count;
  assign len_div       = three ? DVS_W'(sample_count) + {sample_count, 1'b0}
                               : {sample_count, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_sum <= '0;
      utt_count <= '0;
    end else if (state == S_OUT && batch_flag) begin
      batch_sum <= '0;
      utt_count <= '0;
    end else if (state == S_BATCH) begin
      batch_sum <= batch_sum_add;
      utt_count <= utt_count_add;
    end
  end

  // captured quotients
  always_ff @(posedge clk) begin
    if (state == S_DIV_UTT && div_fin) loss <= div_q[LOSS_W-1:0];
    if (state == S_DIV_BATCH && div_fin) batch_mean <= div_q[LOSS_W-1:0];
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept && last_sample) state_next = S_DRAIN;
      S_DRAIN:     state_next = S_SCORE;
      S_SCORE:     if (perm_fin) state_next = S_DIV_UTT;
      S_DIV_UTT:   if (div_fin) state_next = S_BATCH;
      S_BATCH:     state_next = batch_flag ? S_DIV_BATCH : S_OUT;
      S_DIV_BATCH: if (div_fin) state_next = S_OUT;
      S_OUT:       state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy         = 1'b1;
    perm_start   = 1'b0;
    div_start    = 1'b0;
    div_dvd      = DVD_W'(best_score);
    div_dvs      = len_div;
    lane_clr     = 1'b0;
    result_valid = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_DRAIN: perm_start = 1'b1;
      S_SCORE: div_start = perm_fin;
      S_BATCH: begin
        div_start = batch_flag;
        div_dvd   = DVD_W'(batch_sum_add);
        div_dvs   = DVS_W'(utt_count_add);
      end
      S_OUT: begin
        lane_clr     = 1'b1;
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign utterance_loss = loss;
  assign batch_done     = batch_flag;
  assign batch_loss     = batch_flag ? batch_mean : '0;

  // checks
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result shown while idle");

  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> (sample_count == '0 && lane_sums == '0))
    else $error("lanes not cleared after result");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LEN_W'(MAX_LEN)) else $error("sample count overran");

  a_perm_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !three |-> best_permutation < PERM_W'(2))
    else $error("permutation index out of range for two speakers");

endmodule
